@@ sv/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg - shared types and constants of the LRU key/value cache
//
// Field widths, request codes, reset values and the structs that travel
// along and into the row of storage cells.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int unsigned KEY_W           = 32;
    localparam int unsigned VAL_W           = 32;
    localparam int unsigned CAP_W           = 5;
    localparam int unsigned MAX_ENTRIES_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // Request codes
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // Bits for an index or rank over n entries, at least one
    function automatic int unsigned f_bits(input int unsigned n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Lookup token handed from cell to cell
    typedef struct packed {
        logic                    hit;
        logic                    free;
        logic signed [VAL_W-1:0] value;
    } t_scan;

    // Update command broadcast to all cells
    typedef struct packed {
        logic en;
        logic hit;
        logic put;
        logic full_replace;
        logic do_evict;
        logic do_insert;
    } t_upd;

endpackage

@@ sv/lkvc_if.sv @@
// ----------------------------------------------------------------------------
// lkvc_if - request and result channels of the LRU key/value cache
//
// Valid/ready channels; a transfer happens when valid and ready are high
// at a rising clock edge.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   req_type;
    logic signed [lkvc_pkg::KEY_W-1:0]      req_key;
    logic signed [lkvc_pkg::VAL_W-1:0]      req_value;

    modport source (output valid, output req_type, output req_key, output req_value,
                    input ready);
    modport sink   (input valid, input req_type, input req_key, input req_value,
                    output ready);
endinterface

interface lkvc_res_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   found;
    logic signed [lkvc_pkg::VAL_W-1:0]      read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

@@ sv/lkvc_cell.sv @@
// ----------------------------------------------------------------------------
// lkvc_cell - one storage cell of the LRU key/value cache
//
// Holds one entry (valid, key, value, recency rank). Every cycle it merges
// its own lookup result into the token from its left neighbor and hands the
// token on; on an update command it applies its share of the LRU update.
// ----------------------------------------------------------------------------
module lkvc_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned RW  = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [lkvc_pkg::KEY_W-1:0] i_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0] i_value,
    input  lkvc_pkg::t_scan                   i_tok,
    input  logic [RW-1:0]                     i_tok_rank,
    input  logic [RW-1:0]                     i_tok_idx,
    output lkvc_pkg::t_scan                   o_tok,
    output logic [RW-1:0]                     o_tok_rank,
    output logic [RW-1:0]                     o_tok_idx,
    input  lkvc_pkg::t_upd                    i_upd,
    input  logic [RW-1:0]                     i_hit_rank,
    input  logic [RW-1:0]                     i_victim_rank,
    input  logic [RW-1:0]                     i_free_idx
);
    import lkvc_pkg::*;

    logic                    r_valid;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_value;
    logic [RW-1:0]           r_rank;
    t_scan                   r_tok;
    logic [RW-1:0]           r_tok_rank;
    logic [RW-1:0]           r_tok_idx;

    logic w_match;
    logic w_victim;
    logic w_free_sel;

    assign w_match    = r_valid && (r_key == i_key);
    assign w_victim   = r_valid && (r_rank == i_victim_rank);
    assign w_free_sel = !r_valid && (i_free_idx == RW'(IDX));

    // Merge own lookup into the passing token; the first hit and first free win
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok      <= '0;
            r_tok_rank <= '0;
            r_tok_idx  <= '0;
        end else begin
            r_tok.hit  <= i_tok.hit || w_match;
            r_tok.free <= i_tok.free || !r_valid;
            if (i_tok.hit) begin
                r_tok.value <= i_tok.value;
                r_tok_rank  <= i_tok_rank;
            end else begin
                r_tok.value <= r_value;
                r_tok_rank  <= r_rank;
            end
            if (i_tok.free) begin
                r_tok_idx <= i_tok_idx;
            end else begin
                r_tok_idx <= RW'(IDX);
            end
        end
    end

    assign o_tok      = r_tok;
    assign o_tok_rank = r_tok_rank;
    assign o_tok_idx  = r_tok_idx;

    // Apply the update command: touch, replace, evict, insert or age
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.en) begin
            if (i_upd.hit) begin
                if (w_match) begin
                    r_rank <= '0;
                    if (i_upd.put) begin
                        r_value <= i_value;
                    end
                end else if (r_valid && (r_rank < i_hit_rank)) begin
                    r_rank <= r_rank + RW'(1);
                end
            end else if (i_upd.put) begin
                if (i_upd.full_replace && w_victim) begin
                    r_key   <= i_key;
                    r_value <= i_value;
                    r_rank  <= '0;
                end else if (i_upd.do_evict && w_victim) begin
                    r_valid <= 1'b0;
                    r_rank  <= '0;
                end else if (i_upd.do_insert && !i_upd.full_replace && w_free_sel) begin
                    r_valid <= 1'b1;
                    r_key   <= i_key;
                    r_value <= i_value;
                    r_rank  <= '0;
                end else if (r_valid) begin
                    r_rank <= r_rank + RW'(1);
                end
            end
        end
    end

endmodule

@@ sv/lru_key_value_cache_top.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_top - fully associative key/value cache, LRU eviction
//
// Channel   Dir  Handshake       Payload
// i_req     in   valid/ready     req_type, req_key, req_value
// o_res     out  valid/ready     found, read_value (gets only)
// i_cfg_*   in   write enable    capacity_in_use (5 bits)
//
// For each request the lookup token walks the cell row one cell per cycle,
// then the update is broadcast to all cells.
// A get result appears in the cycle after the update and waits in an output
// register while the next request is accepted; a get stalls in its update
// cycle only while the previous result is still unread.
// Reset is synchronous, active low, and empties the cache at once.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
    parameter int unsigned MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lkvc_req_if.sink                          i_req,
    lkvc_res_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]        i_cfg_data
);
    import lkvc_pkg::*;

    localparam int unsigned RW = f_bits(MAX_ENTRIES);
    localparam int unsigned OW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CW = (OW > CAP_W) ? OW : CAP_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPD} t_state;

    t_state                  r_state;
    logic [RW-1:0]           r_cnt;
    logic [OW-1:0]           r_occ;
    logic [OW-1:0]           n_occ;
    logic [CAP_W-1:0]        r_cap;
    logic                    r_type;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_value;
    logic                    r_out_valid;
    logic                    r_out_found;
    logic signed [VAL_W-1:0] r_out_value;

    t_scan                   w_tok      [MAX_ENTRIES+1];
    logic [RW-1:0]           w_tok_rank [MAX_ENTRIES+1];
    logic [RW-1:0]           w_tok_idx  [MAX_ENTRIES+1];

    t_scan                   w_tail;
    t_upd                    w_upd;
    logic                    w_fire;
    logic                    w_full;
    logic                    w_evict;
    logic [CW-1:0]           w_eff_cap;
    logic [OW-1:0]           w_occ_m1;

    // Start every token empty at the head of the row
    assign w_tok[0]      = '0;
    assign w_tok_rank[0] = '0;
    assign w_tok_idx[0]  = '0;
    assign w_tail        = w_tok[MAX_ENTRIES];

    // Decide the update from the token that left the last cell
    assign w_full    = (r_occ == OW'(MAX_ENTRIES));
    assign w_eff_cap = (CW'(r_cap) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(r_cap);
    assign w_evict   = w_full || (CW'(r_occ) >= w_eff_cap);
    assign w_occ_m1  = r_occ - OW'(1);
    assign w_fire    = (r_state == ST_UPD) &&
                       ((r_type == REQ_PUT) || !r_out_valid || o_res.ready);

    always_comb begin
        w_upd.en           = w_fire;
        w_upd.hit          = w_tail.hit;
        w_upd.put          = (r_type == REQ_PUT);
        w_upd.full_replace = w_full;
        w_upd.do_evict     = w_evict && !w_full && (r_occ != '0);
        w_upd.do_insert    = !w_full && !(w_evict && (r_occ == '0));
    end

    // Occupancy grows only on an insert that needs no eviction
    always_comb begin
        n_occ = r_occ;
        if (w_fire && (r_type == REQ_PUT) && !w_tail.hit && !w_evict) begin
            n_occ = r_occ + OW'(1);
        end
    end

    // Row of storage cells
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lkvc_cell #(
            .IDX (g),
            .RW  (RW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_key         (r_key),
            .i_value       (r_value),
            .i_tok         (w_tok[g]),
            .i_tok_rank    (w_tok_rank[g]),
            .i_tok_idx     (w_tok_idx[g]),
            .o_tok         (w_tok[g+1]),
            .o_tok_rank    (w_tok_rank[g+1]),
            .o_tok_idx     (w_tok_idx[g+1]),
            .i_upd         (w_upd),
            .i_hit_rank    (w_tok_rank[MAX_ENTRIES]),
            .i_victim_rank (w_occ_m1[RW-1:0]),
            .i_free_idx    (w_tok_idx[MAX_ENTRIES])
        );
    end

    // Sequence the request, hold capacity, occupancy and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_occ       <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            r_occ <= n_occ;
            if (o_res.valid && o_res.ready && !(w_fire && (r_type == REQ_GET))) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_type  <= i_req.req_type;
                        r_key   <= i_req.req_key;
                        r_value <= i_req.req_value;
                        r_cnt   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_cnt == RW'(MAX_ENTRIES - 1)) begin
                        r_state <= ST_UPD;
                    end else begin
                        r_cnt <= r_cnt + RW'(1);
                    end
                end
                ST_UPD: begin
                    if (w_fire) begin
                        if (r_type == REQ_GET) begin
                            r_out_valid <= 1'b1;
                            r_out_found <= w_tail.hit;
                            r_out_value <= w_tail.hit ? w_tail.value : MISS_VALUE;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.found      = r_out_found;
    assign o_res.read_value = r_out_value;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(MAX_ENTRIES))
        else $error("occupancy above table size");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_type == REQ_PUT) && !w_tail.hit && !w_evict)
        |=> (r_occ == $past(r_occ) + OW'(1)))
        else $error("insert without eviction did not grow occupancy");

    a_hit_keeps_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_tail.hit) |=> (r_occ == $past(r_occ)))
        else $error("hit changed occupancy");

    a_get_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_type == REQ_GET)) |=> r_out_valid)
        else $error("get finished without a result");
`endif

endmodule
